FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers used by the back end of the box sum block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_PROP(name, clock, resetn, prop) \
    name: assert property (@(posedge clock) disable iff (!resetn) (prop)) \
        else $error("assertion failed");

`define ASSERT_NEVER(name, clock, resetn, cond) \
    name: assert property (@(posedge clock) disable iff (!resetn) !(cond)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_PROP(name, clock, resetn, prop)

`define ASSERT_NEVER(name, clock, resetn, cond)

`endif

`endif

FILE: src/bb3_pkg.sv
// ----------------------------------------------------------------------------
// Box sum package
// Widths, register indexes and the pipeline record shared by the block.
// ----------------------------------------------------------------------------
package bb3_pkg;

    localparam int MAX_WIDTH    = 1024;
    localparam int PIXEL_BITS   = 8;
    localparam int ADDR_W       = $clog2(MAX_WIDTH);
    localparam int ROW_SUM_W    = PIXEL_BITS + 2;
    localparam int BOX_SUM_W    = 12;
    localparam int COUNT_W      = 11;
    localparam int CFG_W        = 11;
    localparam int CFG_INDEX_W  = 2;
    localparam int IN_TDATA_W   = ((PIXEL_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W  = ((BOX_SUM_W + 7) / 8) * 8;
    localparam int STORE_W      = 2 * ROW_SUM_W;
    localparam int HEIGHT_LIMIT = 2045;
    localparam int WIDTH_RESET  = 32;
    localparam int HEIGHT_RESET = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_OUT_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_OUT_HEIGHT = 2'd1;

    typedef struct packed {
        logic                 valid;
        logic                 active;
        logic                 emit;
        logic                 sel;
        logic [ADDR_W-1:0]    x;
        logic [ROW_SUM_W-1:0] hsum;
        logic                 row_end;
        logic                 frame_end;
    } stage_t;

endpackage

FILE: src/bb3_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module bb3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/bb3_front.sv
// ----------------------------------------------------------------------------
// Box sum front end
// Configuration registers, position counters, horizontal sum and store read.
// ----------------------------------------------------------------------------
module bb3_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [bb3_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [bb3_pkg::CFG_W-1:0]        cfg_wdata,
    input  logic                             in_accept,
    input  logic [bb3_pkg::PIXEL_BITS-1:0]   pixel,
    input  logic                             frame_start,
    input  logic                             advance,
    output bb3_pkg::stage_t                  stage,
    output logic                             ram_re,
    output logic [bb3_pkg::ADDR_W-1:0]       ram_raddr
);

    import bb3_pkg::*;

    logic [CFG_W-1:0]      out_width_reg;
    logic [CFG_W-1:0]      out_height_reg;
    logic [COUNT_W-1:0]    col_reg;
    logic [COUNT_W-1:0]    col_next;
    logic [COUNT_W-1:0]    row_reg;
    logic [COUNT_W-1:0]    row_next;
    logic                  sel_reg;
    logic                  sel_next;
    logic [PIXEL_BITS-1:0] prev0_reg;
    logic [PIXEL_BITS-1:0] prev1_reg;
    stage_t                stage_reg;
    stage_t                stage_next;

    logic [COUNT_W-1:0]    col_cur;
    logic [COUNT_W-1:0]    row_cur;
    logic                  sel_cur;
    logic [COUNT_W-1:0]    width_clamped;
    logic [COUNT_W-1:0]    height_clamped;
    logic [COUNT_W-1:0]    last_col;
    logic [COUNT_W-1:0]    last_row;
    logic                  at_row_end;
    logic                  at_frame_end;
    logic                  active;
    logic [COUNT_W-1:0]    col_off;
    logic [ROW_SUM_W-1:0]  hsum;

    always_comb
    begin
        col_cur = frame_start ? '0 : col_reg;
        row_cur = frame_start ? '0 : row_reg;
        sel_cur = frame_start ? 1'b0 : sel_reg;

        if (out_width_reg == '0)
        begin
            width_clamped = COUNT_W'(1);
        end
        else if (out_width_reg > CFG_W'(MAX_WIDTH))
        begin
            width_clamped = COUNT_W'(MAX_WIDTH);
        end
        else
        begin
            width_clamped = out_width_reg;
        end

        if (out_height_reg == '0)
        begin
            height_clamped = COUNT_W'(1);
        end
        else if (out_height_reg > CFG_W'(HEIGHT_LIMIT))
        begin
            height_clamped = COUNT_W'(HEIGHT_LIMIT);
        end
        else
        begin
            height_clamped = out_height_reg;
        end

        last_col     = width_clamped + COUNT_W'(1);
        last_row     = height_clamped + COUNT_W'(1);
        at_row_end   = col_cur >= last_col;
        at_frame_end = at_row_end && (row_cur >= last_row);
        active       = col_cur >= COUNT_W'(2);
        col_off      = col_cur - COUNT_W'(2);
        hsum         = ROW_SUM_W'(pixel) + ROW_SUM_W'(prev0_reg) + ROW_SUM_W'(prev1_reg);

        if (at_row_end)
        begin
            col_next = '0;
            if (row_cur >= last_row)
            begin
                row_next = '0;
                sel_next = 1'b0;
            end
            else
            begin
                row_next = row_cur + COUNT_W'(1);
                sel_next = ~sel_cur;
            end
        end
        else
        begin
            col_next = col_cur + COUNT_W'(1);
            row_next = row_cur;
            sel_next = sel_cur;
        end

        stage_next = stage_reg;
        if (in_accept)
        begin
            stage_next.valid     = 1'b1;
            stage_next.active    = active;
            stage_next.emit      = active && (row_cur >= COUNT_W'(2));
            stage_next.sel       = sel_cur;
            stage_next.x         = col_off[ADDR_W-1:0];
            stage_next.hsum      = hsum;
            stage_next.row_end   = at_row_end;
            stage_next.frame_end = at_frame_end;
        end
        else if (advance)
        begin
            stage_next.valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_width_reg   <= CFG_W'(WIDTH_RESET);
            out_height_reg  <= CFG_W'(HEIGHT_RESET);
            col_reg         <= '0;
            row_reg         <= '0;
            sel_reg         <= 1'b0;
            prev0_reg       <= '0;
            prev1_reg       <= '0;
            stage_reg       <= '0;
        end
        else
        begin
            if (cfg_we && (cfg_index == REG_OUT_WIDTH))
            begin
                out_width_reg <= cfg_wdata;
            end
            if (cfg_we && (cfg_index == REG_OUT_HEIGHT))
            begin
                out_height_reg <= cfg_wdata;
            end
            if (in_accept)
            begin
                col_reg   <= col_next;
                row_reg   <= row_next;
                sel_reg   <= sel_next;
                prev0_reg <= pixel;
                prev1_reg <= prev0_reg;
            end
            stage_reg <= stage_next;
        end
    end

    assign stage     = stage_reg;
    assign ram_re    = in_accept && active;
    assign ram_raddr = col_off[ADDR_W-1:0];

endmodule

FILE: src/bb3_back.sv
// ----------------------------------------------------------------------------
// Box sum back end
// Vertical sum, line store write-back and the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bb3_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  bb3_pkg::stage_t                stage,
    input  logic [bb3_pkg::STORE_W-1:0]    ram_rdata,
    input  logic                           out_ready,
    output logic                           advance,
    output logic                           ram_we,
    output logic [bb3_pkg::ADDR_W-1:0]     ram_waddr,
    output logic [bb3_pkg::STORE_W-1:0]    ram_wdata,
    output logic                           out_valid,
    output logic [bb3_pkg::BOX_SUM_W-1:0]  box_sum,
    output logic                           row_end,
    output logic                           frame_end
);

    import bb3_pkg::*;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [BOX_SUM_W-1:0] box_sum_reg;
    logic                 row_end_reg;
    logic                 frame_end_reg;
    logic [ROW_SUM_W-1:0] half_lo;
    logic [ROW_SUM_W-1:0] half_hi;
    logic [ROW_SUM_W-1:0] old_sum;
    logic [ROW_SUM_W-1:0] mid_sum;
    logic [BOX_SUM_W-1:0] total;
    logic                 load;

    always_comb
    begin
        half_lo = ram_rdata[ROW_SUM_W-1:0];
        half_hi = ram_rdata[STORE_W-1:ROW_SUM_W];
        old_sum = stage.sel ? half_hi : half_lo;
        mid_sum = stage.sel ? half_lo : half_hi;
        total   = BOX_SUM_W'(old_sum) + BOX_SUM_W'(mid_sum) + BOX_SUM_W'(stage.hsum);

        advance = stage.valid && (!stage.emit || !out_valid_reg || out_ready);
        load    = advance && stage.emit;

        ram_we    = advance && stage.active;
        ram_waddr = stage.x;
        ram_wdata = stage.sel ? {stage.hsum, half_lo} : {half_hi, stage.hsum};

        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            box_sum_reg   <= total;
            row_end_reg   <= stage.row_end;
            frame_end_reg <= stage.frame_end;
        end
    end

    assign out_valid = out_valid_reg;
    assign box_sum   = box_sum_reg;
    assign row_end   = row_end_reg;
    assign frame_end = frame_end_reg;

    `ASSERT_PROP(a_load_shows, clk, rst_n, load |=> out_valid_reg)
    `ASSERT_PROP(a_frame_end_row_end, clk, rst_n, (out_valid_reg && frame_end_reg) |-> row_end_reg)
    `ASSERT_NEVER(a_write_without_item, clk, rst_n, ram_we && !stage.valid)

endmodule

FILE: src/box_blur_3x3_sum_top.sv
// ----------------------------------------------------------------------------
// 3x3 box sum top level
// Streaming separable 3x3 box sum over a padded raster frame.
//
// Channel   Direction  Contents
// s_axis    in         tdata: pixel; tuser: frame_start
// m_axis    out        tdata: box_sum; tlast: row_end; tuser: frame_end
// cfg       in         index 0: out_width, index 1: out_height
//
// One pixel is taken per cycle unless a stalled output holds one pixel in the
// middle stage; a result passes the middle stage and the output register. The
// line store is read when a pixel is taken and written back as it leaves the
// middle stage, so its single read and write ports set the rate. Reset clears
// counters, previous pixels and valid flags; the store is not cleared.
// ----------------------------------------------------------------------------
module box_blur_3x3_sum_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [bb3_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [bb3_pkg::CFG_W-1:0]          cfg_wdata,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [bb3_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // pixel
    input  logic                               s_axis_tuser,  // frame_start
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [bb3_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,  // box_sum
    output logic                               m_axis_tlast,
    output logic                               m_axis_tuser   // frame_end
);

    import bb3_pkg::*;

    stage_t               stage;
    logic                 advance;
    logic                 in_accept;
    logic                 ram_re;
    logic [ADDR_W-1:0]    ram_raddr;
    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr;
    logic [STORE_W-1:0]   ram_wdata;
    logic [STORE_W-1:0]   ram_rdata;
    logic [BOX_SUM_W-1:0] box_sum;

    assign s_axis_tready = !stage.valid || advance;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    bb3_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .in_accept   (in_accept),
        .pixel       (s_axis_tdata[PIXEL_BITS-1:0]),
        .frame_start (s_axis_tuser),
        .advance     (advance),
        .stage       (stage),
        .ram_re      (ram_re),
        .ram_raddr   (ram_raddr)
    );

    bb3_ram #(
        .WIDTH (STORE_W),
        .DEPTH (MAX_WIDTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bb3_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .stage     (stage),
        .ram_rdata (ram_rdata),
        .out_ready (m_axis_tready),
        .advance   (advance),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .out_valid (m_axis_tvalid),
        .box_sum   (box_sum),
        .row_end   (m_axis_tlast),
        .frame_end (m_axis_tuser)
    );

    assign m_axis_tdata = OUT_TDATA_W'(box_sum);

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// 3x3 box sum regression bench
// Streams padded raster frames into the box sum block and checks every
// result transaction against an in-bench prediction of the separable sum.
// Covers tiny and wide frame sizes, out-of-range register values, frames
// that wrap without a start mark, restarted frames, mid-frame narrowing and
// random stalls on both streams, including long output hold-offs.
// ----------------------------------------------------------------------------
module testbench;

    import bb3_pkg::*;

    localparam int RANDOM_ITEMS = 850;
    localparam int DRAIN_CYCLES = 8;
    localparam int END_LIMIT    = 5000;
    localparam int LONG_HOLD    = 400;
    localparam int MAX_PRINTS   = 100;
    localparam int RANDOM_ROWS  = 12;
    localparam int ALL_ROWS     = 1 << 20;
    localparam int HOLD_ROWS    = 6;
    localparam int WIDE_PIXELS  = 40;
    localparam int BURST_WIDTH  = 60;

    localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

    typedef enum {FILL_RANDOM, FILL_HIGH, FILL_LOW, FILL_EXTREME} fill_t;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] pixel;
        logic                  frame_start;
    } pixel_item_t;

    typedef struct packed {
        logic [BOX_SUM_W-1:0] box_sum;
        logic                 row_end;
        logic                 frame_end;
    } box_result_t;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   cfg_we        = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index     = '0;
    logic [CFG_W-1:0]       cfg_wdata     = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   s_axis_tuser  = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tlast;
    logic                   m_axis_tuser;

    pixel_item_t pixel_queue[$];
    box_result_t sum_queue[$];
    pixel_item_t next_item;
    box_result_t front_sum;

    logic [CFG_W-1:0]     cfg_width  = CFG_W'(WIDTH_RESET);
    logic [CFG_W-1:0]     cfg_height = CFG_W'(HEIGHT_RESET);
    logic [ROW_SUM_W-1:0] row_sums [2*MAX_WIDTH];
    logic [PIXEL_BITS-1:0] prev_pix [2] = '{'0, '0};
    logic [COUNT_W-1:0]   col_pos  = '0;
    logic [COUNT_W-1:0]   row_pos  = '0;
    logic                 half_sel = 1'b0;

    int  error_count  = 0;
    int  queued_count = 0;
    int  tx_gap       = 0;
    int  rx_stall     = 0;
    int  hold_token   = 0;
    int  hold_seen    = 0;
    bit  tx_no_idle   = 1'b0;
    bit  rx_no_idle   = 1'b0;
    bit  need_start   = 1'b0;

    box_blur_3x3_sum_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        if (error_count < MAX_PRINTS)
        begin
            $display("ERROR at %0t: %s", $realtime, what);
        end
        error_count++;
    endtask

    function automatic int random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic int active_width();
        if (cfg_width == 0)
            return 1;
        else if (cfg_width > MAX_WIDTH)
            return MAX_WIDTH;
        else
            return int'(cfg_width);
    endfunction

    function automatic int active_height();
        if (cfg_height == 0)
            return 1;
        else if (cfg_height > HEIGHT_LIMIT)
            return HEIGHT_LIMIT;
        else
            return int'(cfg_height);
    endfunction

    // Advances the box sum state by one accepted pixel and queues the
    // result that the pixel completes, if any.
    task automatic predict_box_sum(input logic [PIXEL_BITS-1:0] pix, input logic start);
        int          last_col;
        int          last_row;
        int          x;
        int          old_idx;
        int          mid_idx;
        logic [ROW_SUM_W-1:0] hsum;
        logic        at_row_end;
        logic        at_frame_end;
        box_result_t res;
        last_col = active_width() + 1;
        last_row = active_height() + 1;
        if (start)
        begin
            col_pos  = '0;
            row_pos  = '0;
            half_sel = 1'b0;
        end
        at_row_end   = (col_pos >= last_col);
        at_frame_end = at_row_end && (row_pos >= last_row);
        if (col_pos >= 2)
        begin
            x       = (int'(col_pos) - 2) % MAX_WIDTH;
            hsum    = ROW_SUM_W'(pix) + ROW_SUM_W'(prev_pix[0]) + ROW_SUM_W'(prev_pix[1]);
            old_idx = (half_sel ? MAX_WIDTH : 0) + x;
            mid_idx = (half_sel ? 0 : MAX_WIDTH) + x;
            if (row_pos >= 2)
            begin
                res.box_sum   = BOX_SUM_W'(row_sums[old_idx]) + BOX_SUM_W'(row_sums[mid_idx])
                                + BOX_SUM_W'(hsum);
                res.row_end   = at_row_end;
                res.frame_end = at_frame_end;
                sum_queue.push_back(res);
            end
            row_sums[old_idx] = hsum;
        end
        prev_pix[1] = prev_pix[0];
        prev_pix[0] = pix;
        if (at_row_end)
        begin
            col_pos = '0;
            if (row_pos >= last_row)
            begin
                row_pos  = '0;
                half_sel = 1'b0;
            end
            else
            begin
                row_pos  = row_pos + 1'b1;
                half_sel = ~half_sel;
            end
        end
        else
        begin
            col_pos = col_pos + 1'b1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= 1'b0;
            tx_gap        <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_box_sum(s_axis_tdata[PIXEL_BITS-1:0], s_axis_tuser);
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (tx_gap > 0)
                begin
                    tx_gap        <= tx_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pixel_queue.size() > 0)
                begin
                    next_item      = pixel_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= IN_TDATA_W'(next_item.pixel);
                    s_axis_tuser  <= next_item.frame_start;
                    tx_gap        <= tx_no_idle ? 0 : random_gap();
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            rx_stall      <= 0;
            hold_seen     <= 0;
        end
        else if (hold_token != hold_seen)
        begin
            hold_seen     <= hold_token;
            rx_stall      <= LONG_HOLD;
            m_axis_tready <= 1'b0;
        end
        else if (rx_stall > 0)
        begin
            rx_stall      <= rx_stall - 1;
            m_axis_tready <= 1'b0;
        end
        else if (rx_no_idle)
        begin
            m_axis_tready <= 1'b1;
        end
        else
        begin
            int gap;
            gap = random_gap();
            m_axis_tready <= (gap == 0);
            rx_stall      <= (gap > 0) ? gap - 1 : 0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (sum_queue.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result transaction, tdata %0d",
                                          m_axis_tdata));
            end
            else
            begin
                front_sum = sum_queue.pop_front();
                if (m_axis_tdata !== OUT_TDATA_W'(front_sum.box_sum))
                    report_mismatch($sformatf("box_sum got %0d, wanted %0d",
                                              m_axis_tdata, front_sum.box_sum));
                if (m_axis_tlast !== front_sum.row_end)
                    report_mismatch($sformatf("row_end got %b, wanted %b",
                                              m_axis_tlast, front_sum.row_end));
                if (m_axis_tuser !== front_sum.frame_end)
                    report_mismatch($sformatf("frame_end got %b, wanted %b",
                                              m_axis_tuser, front_sum.frame_end));
            end
        end
    end

    task automatic wait_idle();
        do
            @(negedge clk);
        while (pixel_queue.size() != 0 || s_axis_tvalid || sum_queue.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CFG_W'(value);
        if (idx == REG_OUT_WIDTH)
            cfg_width = CFG_W'(value);
        else if (idx == REG_OUT_HEIGHT)
            cfg_height = CFG_W'(value);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // A size change always restarts the frame, so the line store is rewritten
    // by the first two rows before any entry of the new width is read.
    task automatic set_size(input int w, input int h);
        wait_idle();
        write_reg(REG_OUT_WIDTH, w);
        write_reg(REG_OUT_HEIGHT, h);
        need_start = 1'b1;
    endtask

    function automatic logic [PIXEL_BITS-1:0] draw_pixel(input fill_t fill);
        case (fill)
            FILL_HIGH:    return {PIXEL_BITS{1'b1}};
            FILL_LOW:     return '0;
            FILL_EXTREME: return $urandom_range(0, 1) ? {PIXEL_BITS{1'b1}} : '0;
            default:      return PIXEL_BITS'($urandom_range(0, (1 << PIXEL_BITS) - 1));
        endcase
    endfunction

    task automatic push_pixel(input logic [PIXEL_BITS-1:0] pix, input logic start);
        pixel_item_t item;
        item.pixel       = pix;
        item.frame_start = start | need_start;
        need_start       = 1'b0;
        pixel_queue.push_back(item);
        queued_count++;
    endtask

    task automatic queue_pixels(input int count, input fill_t fill, input bit start,
                                input int start_pct);
        for (int i = 0; i < count; i++)
        begin
            push_pixel(draw_pixel(fill),
                       (i == 0 && start) || ($urandom_range(0, 99) < start_pct));
        end
    endtask

    task automatic queue_frame(input fill_t fill, input bit start, input int max_rows);
        int rows;
        rows = active_height() + 2;
        if (rows > max_rows)
            rows = max_rows;
        queue_pixels(rows * (active_width() + 2), fill, start, 0);
    endtask

    function automatic fill_t random_fill();
        if ($urandom_range(0, 9) < 7)
            return FILL_RANDOM;
        else
            return fill_t'($urandom_range(1, 3));
    endfunction

    function automatic int random_width();
        int r;
        r = $urandom_range(0, 99);
        return (r < 10) ? 0 : $urandom_range(1, 6);
    endfunction

    function automatic int random_height();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return $urandom_range(2040, 2047);
        else if (r < 15)
            return 0;
        else
            return $urandom_range(1, 5);
    endfunction

    initial
    begin : stimulus
        int goal;
        int kind;
        int frame_px;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: smallest frame at full scale, a wrapped frame, extremes mix.
        set_size(1, 1);
        write_reg(REG_SPARE, $urandom_range(0, (1 << CFG_W) - 1));
        queue_frame(FILL_HIGH, 1'b1, ALL_ROWS);
        queue_frame(FILL_LOW, 1'b0, ALL_ROWS);
        queue_frame(FILL_EXTREME, 1'b1, ALL_ROWS);

        // Reset-sized rows with a long output hold-off while input keeps coming.
        set_size(WIDTH_RESET, HEIGHT_RESET);
        tx_no_idle <= 1'b1;
        hold_token <= hold_token + 1;
        queue_frame(FILL_RANDOM, 1'b1, HOLD_ROWS);
        wait_idle();
        tx_no_idle <= 1'b0;

        set_size((1 << CFG_W) - 1, 0);
        queue_pixels(WIDE_PIXELS, FILL_RANDOM, 1'b1, 0);

        set_size(BURST_WIDTH, 2);
        tx_no_idle <= 1'b1;
        rx_no_idle <= 1'b1;
        queue_frame(FILL_RANDOM, 1'b1, ALL_ROWS);
        wait_idle();
        tx_no_idle <= 1'b0;
        rx_no_idle <= 1'b0;

        set_size(0, (1 << CFG_W) - 1);
        queue_frame(FILL_RANDOM, 1'b1, RANDOM_ROWS);

        set_size(random_width(), random_height());
        goal = queued_count + RANDOM_ITEMS;
        while (queued_count < goal)
        begin
            kind = $urandom_range(0, 99);
            frame_px = (active_width() + 2) * (active_height() + 2);
            if (frame_px > (active_width() + 2) * RANDOM_ROWS)
                frame_px = (active_width() + 2) * RANDOM_ROWS;
            if (kind < 15)
            begin
                set_size(random_width(), random_height());
            end
            else if (kind < 65)
            begin
                queue_frame(random_fill(), $urandom_range(0, 1), RANDOM_ROWS);
            end
            else if (kind < 78)
            begin
                queue_pixels($urandom_range(1, frame_px - 1), random_fill(), 1'b1, 0);
            end
            else if (kind < 90)
            begin
                queue_pixels($urandom_range(1, 16), FILL_RANDOM, 1'b0, 10);
            end
            else
            begin
                // Mid-frame change: the row may only narrow, the height may move freely.
                wait_idle();
                if ($urandom_range(0, 1))
                    write_reg(REG_OUT_WIDTH, $urandom_range(0, active_width()));
                else
                    write_reg(REG_OUT_HEIGHT, $urandom_range(0, 6));
                queue_pixels($urandom_range(1, 24), FILL_RANDOM, 1'b0, 0);
            end
            if ($urandom_range(0, 19) == 0)
                tx_no_idle <= ~tx_no_idle;
            if ($urandom_range(0, 19) == 0)
                rx_no_idle <= ~rx_no_idle;
            if ($urandom_range(0, 199) == 0)
                hold_token <= hold_token + 1;
        end

        do
            @(negedge clk);
        while (pixel_queue.size() != 0 || s_axis_tvalid);
        for (int n = 0; n < END_LIMIT && sum_queue.size() != 0; n++)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (sum_queue.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived",
                                      sum_queue.size()));
        if (error_count == 0)
            $display("box_blur_3x3_sum_top regression: pass");
        else
            $display("box_blur_3x3_sum_top regression: fail");
        $finish;
    end

    initial
    begin
        #15_000_000;
        $display("ERROR: simulation timed out");
        $display("box_blur_3x3_sum_top regression: fail");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+src
src/bb3_pkg.sv
src/bb3_ram.sv
src/bb3_front.sv
src/bb3_back.sv
src/box_blur_3x3_sum_top.sv
tb/testbench.sv
